>>> src/bde_pkg.sv
// ----------------------------------------------------------------------------
// bde_pkg
// Shared types, constants and helper functions of the bounded deque engine.
// ----------------------------------------------------------------------------
package bde_pkg;

    // sizing
    localparam int CAPACITY   = 32;
    localparam int VALUE_BITS = 32;
    localparam int DATA_W     = 32;
    localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int SUM_W      = $clog2(2 * CAPACITY);

    typedef logic [VALUE_BITS-1:0] t_store;
    typedef logic [IDX_W-1:0]      t_idx;
    typedef logic [CNT_W-1:0]      t_cnt;

    // operation codes
    typedef enum logic [2:0] {
        FN_INS_FRONT = 3'd0,
        FN_INS_BACK  = 3'd1,
        FN_REM_FRONT = 3'd2,
        FN_REM_BACK  = 3'd3,
        FN_DUMP      = 3'd4
    } t_func;

    // result codes
    typedef enum logic [1:0] {
        OC_OK    = 2'd0,
        OC_EMPTY = 2'd1,
        OC_FULL  = 2'd2,
        OC_ENTRY = 2'd3
    } t_outcome;

    // controller states
    typedef enum logic [0:0] {
        ST_IDLE = 1'b0,
        ST_DUMP = 1'b1
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic     load_status;
        t_outcome status_code;
        logic     push_front;
        logic     push_back;
        logic     pop_front;
        logic     pop_back;
        logic     dump_start;
        logic     dump_step;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic empty;
        logic full;
        logic dump_last;
        logic out_free;
    } t_status;

    // cut an input value to the stored width
    function automatic t_store to_stored(input logic [DATA_W-1:0] v);
        logic signed [63:0] ext;
        ext = 64'(signed'(v));
        return ext[VALUE_BITS-1:0];
    endfunction

    // sign extend a stored value back to the bus width
    function automatic logic [DATA_W-1:0] from_stored(input t_store s);
        logic signed [63:0] ext;
        ext = 64'(signed'(s));
        return ext[DATA_W-1:0];
    endfunction

endpackage

>>> src/bde_ctrl.sv
// ----------------------------------------------------------------------------
// bde_ctrl
// Controller: decodes each operation and sequences the dump of the store.
// ----------------------------------------------------------------------------
module bde_ctrl
    import bde_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_func   i_func,
    input  t_status i_status,
    output logic    o_in_ready,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   w_accept;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign w_accept = i_in_valid && o_in_ready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept && i_func == FN_DUMP && !i_status.empty) begin
                    n_state = ST_DUMP;
                end
            end
            ST_DUMP: begin
                if (i_status.out_free && i_status.dump_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = i_status.out_free;
                if (w_accept) begin
                    unique case (i_func)
                        FN_INS_FRONT, FN_INS_BACK: begin
                            o_cmd.load_status = 1'b1;
                            if (i_status.full) begin
                                o_cmd.status_code = OC_FULL;
                            end else begin
                                o_cmd.status_code = OC_OK;
                                o_cmd.push_front  = (i_func == FN_INS_FRONT);
                                o_cmd.push_back   = (i_func == FN_INS_BACK);
                            end
                        end
                        FN_REM_FRONT, FN_REM_BACK: begin
                            o_cmd.load_status = 1'b1;
                            if (i_status.empty) begin
                                o_cmd.status_code = OC_EMPTY;
                            end else begin
                                o_cmd.status_code = OC_OK;
                                o_cmd.pop_front   = (i_func == FN_REM_FRONT);
                                o_cmd.pop_back    = (i_func == FN_REM_BACK);
                            end
                        end
                        FN_DUMP: begin
                            if (i_status.empty) begin
                                o_cmd.load_status = 1'b1;
                                o_cmd.status_code = OC_EMPTY;
                            end else begin
                                o_cmd.dump_start = 1'b1;
                            end
                        end
                        // unused codes are taken and dropped
                        default: o_cmd = '0;
                    endcase
                end
            end
            ST_DUMP: begin
                o_cmd.dump_step = i_status.out_free;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

>>> src/bde_datapath.sv
// ----------------------------------------------------------------------------
// bde_datapath
// Ring store with head index and count, dump walker and output register.
// ----------------------------------------------------------------------------
module bde_datapath
    import bde_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    input  logic [DATA_W-1:0] i_item_value,
    input  logic              i_out_ready,
    output t_status           o_status,
    output logic              o_out_valid,
    output logic [DATA_W-1:0] o_out_data,
    output t_outcome          o_out_code,
    output logic              o_out_last
);

    t_store            r_mem [CAPACITY];
    t_idx              r_head;
    t_cnt              r_count;
    t_idx              r_dump_slot;
    t_cnt              r_dump_idx;
    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_data;
    t_outcome          r_out_code;
    logic              r_out_last;

    logic [SUM_W-1:0]  w_tail_sum;
    t_idx              w_tail;
    t_idx              w_head_dec;
    t_idx              w_head_inc;
    t_idx              w_slot_inc;
    logic              w_wr_en;
    t_idx              w_wr_addr;

    // ring index arithmetic
    always_comb begin
        w_tail_sum = SUM_W'(r_head) + SUM_W'(r_count);
        if (w_tail_sum >= SUM_W'(CAPACITY)) begin
            w_tail = IDX_W'(w_tail_sum - SUM_W'(CAPACITY));
        end else begin
            w_tail = IDX_W'(w_tail_sum);
        end
        w_head_dec = (r_head == '0) ? IDX_W'(CAPACITY - 1) : r_head - IDX_W'(1);
        w_head_inc = (r_head == IDX_W'(CAPACITY - 1)) ? '0 : r_head + IDX_W'(1);
        w_slot_inc = (r_dump_slot == IDX_W'(CAPACITY - 1)) ? '0
                                                           : r_dump_slot + IDX_W'(1);
    end

    // status back to the controller
    always_comb begin
        o_status.empty     = (r_count == '0);
        o_status.full      = (r_count == CNT_W'(CAPACITY));
        o_status.dump_last = ((r_dump_idx + CNT_W'(1)) == r_count);
        o_status.out_free  = !r_out_valid || i_out_ready;
    end

    // store write port
    assign w_wr_en   = i_cmd.push_front || i_cmd.push_back;
    assign w_wr_addr = i_cmd.push_front ? w_head_dec : w_tail;

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= to_stored(i_item_value);
        end
    end

    // head and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else begin
            if (i_cmd.push_front) begin
                r_head <= w_head_dec;
            end else if (i_cmd.pop_front) begin
                r_head <= w_head_inc;
            end
            if (w_wr_en) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_cmd.pop_front || i_cmd.pop_back) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    // dump walker
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dump_slot <= '0;
            r_dump_idx  <= '0;
        end else if (i_cmd.dump_start) begin
            r_dump_slot <= r_head;
            r_dump_idx  <= '0;
        end else if (i_cmd.dump_step) begin
            r_dump_slot <= w_slot_inc;
            r_dump_idx  <= r_dump_idx + CNT_W'(1);
        end
    end

    // output beat valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_status || i_cmd.dump_step) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output beat payload, store read is registered here
    always_ff @(posedge i_clk) begin
        if (i_cmd.dump_step) begin
            r_out_data <= from_stored(r_mem[r_dump_slot]);
            r_out_code <= OC_ENTRY;
            r_out_last <= o_status.dump_last;
        end else if (i_cmd.load_status) begin
            r_out_data <= '0;
            r_out_code <= i_cmd.status_code;
            r_out_last <= 1'b1;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_out_code  = r_out_code;
    assign o_out_last  = r_out_last;

endmodule

>>> src/bounded_deque_engine.sv
// ----------------------------------------------------------------------------
// bounded_deque_engine
// Bounded double-ended queue of signed values on a ring store.
// ----------------------------------------------------------------------------
// beats: a status beat is valid in the cycle after its input beat; the first entry beat
//   of a dump is read from the ring store once in the dump state and the output is free
// edits: one input beat per cycle while idle and the output is free, one status beat each
// dump: the input is held until the last entry beat is taken, one entry beat per cycle
//   while the output is free, read through the single read port of the ring store
// reset: synchronous, clears head, count, state and output valid; store is not cleared
module bounded_deque_engine
    import bde_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [DATA_W-1:0] s_axis_tdata,   // [31:0] item_value
    input  logic [2:0]        s_axis_tuser,   // [2:0] func
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [DATA_W-1:0] m_axis_tdata,   // [31:0] entry_value
    output logic [1:0]        m_axis_tuser,   // [1:0] outcome
    output logic              m_axis_tlast
);

    t_cmd     w_cmd;
    t_status  w_status;
    t_outcome w_out_code;

    // operation decode and dump sequencing
    bde_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_func     (t_func'(s_axis_tuser)),
        .i_status   (w_status),
        .o_in_ready (s_axis_tready),
        .o_cmd      (w_cmd)
    );

    // store, indexes and output register
    bde_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_item_value (s_axis_tdata),
        .i_out_ready  (m_axis_tready),
        .o_status     (w_status),
        .o_out_valid  (m_axis_tvalid),
        .o_out_data   (m_axis_tdata),
        .o_out_code   (w_out_code),
        .o_out_last   (m_axis_tlast)
    );

    assign m_axis_tuser = w_out_code;

endmodule
